@@ rtl/ssdpm_pkg.sv @@
package ssdpm_pkg;

	localparam int SET_DEPTH_DEF = 32;
	localparam int DIST_W = 31;
	localparam int ID_W = 16;
	localparam int CRD_W = 32;
	localparam int MAP_W = 17;
	localparam int SUM_W = 34;
	// round((sqrt(3) + 0.00005) * 2^16), used to size the sum window.
	localparam logic [16:0] WINDOW_FACTOR = 17'd113515;
	localparam logic [MAP_W-1:0] NO_MAP = '1;
	localparam logic [DIST_W-1:0] DIST_RESET = 31'd655;

	localparam logic ACT_TARGET = 1'b0;
	localparam logic ACT_SOURCE = 1'b1;

	localparam logic [0:0] REG_MERGE_DIST = 1'b0;
	localparam logic [0:0] REG_FOLLOW = 1'b1;

	// One point as it travels from the front end to the store.
	typedef struct packed {
		logic is_source;
		logic final_mark;
		logic [ID_W-1:0] id;
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] z;
		logic [MAP_W-1:0] prior;
	} point_t;

	// One result as it leaves the sweep.
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [MAP_W-1:0] map;
		logic last;
	} result_t;

endpackage

@@ rtl/ssdpm_fifo.sv @@
module ssdpm_fifo #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input ssdpm_pkg::point_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output ssdpm_pkg::point_t rd_data
);

	localparam int AW = $clog2(DEPTH);

	ssdpm_pkg::point_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	// Storage of queued points.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue fill level out of range");

endmodule

@@ rtl/ssdpm_sweep.sv @@
module ssdpm_sweep #(
	parameter int SET_DEPTH = ssdpm_pkg::SET_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [ssdpm_pkg::DIST_W-1:0] merge_distance,
	input logic follow_mode,
	input logic pt_valid,
	output logic pt_ready,
	input ssdpm_pkg::point_t pt_data,
	output logic res_valid,
	input logic res_ready,
	output ssdpm_pkg::result_t res_data
);

	localparam int IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam int SW = ssdpm_pkg::SUM_W;
	localparam int MW = ssdpm_pkg::MAP_W;
	localparam int KW = ssdpm_pkg::CRD_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INS_RD, ST_INS_CMP, ST_INS_WR, ST_SW_SRC, ST_SW_SRC2,
		ST_SW_TGT, ST_SW_TGT2, ST_SW_D1, ST_SW_D2, ST_SW_D3, ST_EMIT
	} state_t;

	// Per-set memories (target = 0, source = 1).
	logic [SW-1:0] sum_mem [2][SET_DEPTH];
	logic [ssdpm_pkg::ID_W-1:0] id_mem [2][SET_DEPTH];
	logic [MW-1:0] pri_mem [2][SET_DEPTH];
	logic [KW-1:0] x_mem [2][SET_DEPTH];
	logic [KW-1:0] y_mem [2][SET_DEPTH];
	logic [KW-1:0] z_mem [2][SET_DEPTH];

	state_t state_q;
	logic [CW-1:0] tcnt_q, scnt_q, pos_q, s_q, t_q, lb_q;
	logic set_q, fin_q, done_q;
	ssdpm_pkg::point_t pt_q;
	logic [SW-1:0] psum_q, rsum_q, ssum_q, w_q;
	logic [ssdpm_pkg::ID_W-1:0] rid_q, sid_q;
	logic [MW-1:0] rpri_q, spri_q, tpri_q, map_q;
	logic [KW-1:0] rx_q, ry_q, rz_q, sx_q, sy_q, sz_q;
	logic [KW:0] dx_q, dy_q, dz_q;
	logic [2*KW+1:0] acc_q;
	logic [ssdpm_pkg::DIST_W+17:0] wprod_q;
	logic [2*ssdpm_pkg::DIST_W-1:0] d2_q;
	logic far_q, tmatch_q, last_q;
	ssdpm_pkg::result_t res_q;
	logic res_v_q;

	logic [IW-1:0] rd_idx, wr_idx;
	logic rd_set;
	logic [KW:0] sqa;
	logic [2*KW+1:0] sq;
	logic shift_up;
	logic signed [SW:0] rsum_x, lo_x, hi_x;

	// Address of the single read port, chosen by state.
	always_comb begin
		rd_set = set_q;
		rd_idx = IW'(pos_q - 1'b1);
		case (state_q)
			ST_SW_SRC, ST_SW_SRC2: begin
				rd_set = ssdpm_pkg::ACT_SOURCE;
				rd_idx = s_q[IW-1:0];
			end
			ST_SW_TGT, ST_SW_TGT2, ST_SW_D1, ST_SW_D2, ST_SW_D3: begin
				rd_set = ssdpm_pkg::ACT_TARGET;
				rd_idx = t_q[IW-1:0];
			end
			default: ;
		endcase
	end

	// Insertion shifts an entry up while it is greater than the new point.
	assign shift_up = ($signed(rsum_q) > $signed(psum_q)) ||
		(rsum_q == psum_q && rid_q > pt_q.id);
	assign wr_idx = pos_q[IW-1:0];

	// Window edges need one bit more than the sums themselves.
	assign rsum_x = $signed({rsum_q[SW-1], rsum_q});
	assign lo_x = $signed({ssum_q[SW-1], ssum_q}) - $signed({1'b0, w_q});
	assign hi_x = $signed({ssum_q[SW-1], ssum_q}) + $signed({1'b0, w_q});

	// Memory read port and write port.
	always_ff @(posedge clk) begin
		rsum_q <= sum_mem[rd_set][rd_idx];
		rid_q <= id_mem[rd_set][rd_idx];
		rpri_q <= pri_mem[rd_set][rd_idx];
		rx_q <= x_mem[rd_set][rd_idx];
		ry_q <= y_mem[rd_set][rd_idx];
		rz_q <= z_mem[rd_set][rd_idx];
		if (state_q == ST_INS_CMP && pos_q != '0 && shift_up) begin
			sum_mem[set_q][wr_idx] <= rsum_q;
			id_mem[set_q][wr_idx] <= rid_q;
			pri_mem[set_q][wr_idx] <= rpri_q;
			x_mem[set_q][wr_idx] <= rx_q;
			y_mem[set_q][wr_idx] <= ry_q;
			z_mem[set_q][wr_idx] <= rz_q;
		end else if (state_q == ST_INS_WR) begin
			sum_mem[set_q][wr_idx] <= psum_q;
			id_mem[set_q][wr_idx] <= pt_q.id;
			pri_mem[set_q][wr_idx] <= pt_q.prior;
			x_mem[set_q][wr_idx] <= pt_q.x;
			y_mem[set_q][wr_idx] <= pt_q.y;
			z_mem[set_q][wr_idx] <= pt_q.z;
		end
	end

	// One squarer, used for one axis per cycle.
	always_comb begin
		case (state_q)
			ST_SW_D2: sqa = dx_q;
			ST_SW_D3: sqa = tmatch_q ? dz_q : dy_q;
			default: sqa = dz_q;
		endcase
		sq = (2*KW+2)'(sqa) * (2*KW+2)'(sqa);
	end

	assign pt_ready = (state_q == ST_IDLE);
	assign res_valid = res_v_q;
	assign res_data = res_q;

	// Control sequencer: insertion sort on load, sweep after the final item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tcnt_q <= '0;
			scnt_q <= '0;
			res_v_q <= 1'b0;
			done_q <= 1'b0;
			lb_q <= '0;
			tmatch_q <= 1'b0;
		end else begin
			if (res_v_q && res_ready && state_q != ST_EMIT) begin
				res_v_q <= 1'b0;
			end
			wprod_q <= 49'(merge_distance) * 49'(ssdpm_pkg::WINDOW_FACTOR) + 49'd65535;
			d2_q <= 62'(merge_distance) * 62'(merge_distance);
			case (state_q)
				ST_IDLE: begin
					if (pt_valid) begin
						pt_q <= pt_data;
						set_q <= pt_data.is_source;
						fin_q <= pt_data.final_mark;
						psum_q <= SW'($signed(pt_data.x)) + SW'($signed(pt_data.y))
							+ SW'($signed(pt_data.z));
						if ((pt_data.is_source ? scnt_q : tcnt_q) == CW'(SET_DEPTH)) begin
							state_q <= pt_data.final_mark ? ST_SW_SRC : ST_IDLE;
							s_q <= '0;
							lb_q <= '0;
							done_q <= 1'b0;
							w_q <= SW'(49'(merge_distance) * 49'(ssdpm_pkg::WINDOW_FACTOR)
								+ 49'd65535 >> 16);
						end else begin
							pos_q <= pt_data.is_source ? scnt_q : tcnt_q;
							state_q <= ST_INS_RD;
						end
					end
				end
				ST_INS_RD: begin
					state_q <= (pos_q == '0) ? ST_INS_WR : ST_INS_CMP;
				end
				ST_INS_CMP: begin
					if (shift_up) begin
						pos_q <= pos_q - 1'b1;
						state_q <= ST_INS_RD;
					end else begin
						state_q <= ST_INS_WR;
					end
				end
				ST_INS_WR: begin
					if (set_q) scnt_q <= scnt_q + 1'b1;
					else tcnt_q <= tcnt_q + 1'b1;
					s_q <= '0;
					lb_q <= '0;
					done_q <= 1'b0;
					w_q <= SW'(wprod_q >> 16);
					state_q <= fin_q ? ST_SW_SRC : ST_IDLE;
				end
				ST_SW_SRC: begin
					if (s_q == scnt_q) begin
						tcnt_q <= '0;
						scnt_q <= '0;
						lb_q <= '0;
						done_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SW_SRC2;
					end
				end
				ST_SW_SRC2: begin
					ssum_q <= rsum_q;
					sid_q <= rid_q;
					spri_q <= rpri_q;
					sx_q <= rx_q;
					sy_q <= ry_q;
					sz_q <= rz_q;
					last_q <= (s_q + 1'b1 == scnt_q);
					t_q <= lb_q;
					if (rpri_q != ssdpm_pkg::NO_MAP) begin
						map_q <= rpri_q;
						state_q <= ST_EMIT;
					end else if (done_q) begin
						map_q <= ssdpm_pkg::NO_MAP;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SW_TGT;
					end
				end
				ST_SW_TGT: begin
					if (t_q == tcnt_q) begin
						if (t_q == lb_q) done_q <= 1'b1;
						map_q <= ssdpm_pkg::NO_MAP;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SW_TGT2;
					end
				end
				ST_SW_TGT2: begin
					// Skip targets below the window for good, stop above it.
					if (rsum_x < lo_x && t_q == lb_q) begin
						lb_q <= lb_q + 1'b1;
						t_q <= t_q + 1'b1;
						state_q <= ST_SW_TGT;
					end else if (rsum_x > hi_x) begin
						map_q <= ssdpm_pkg::NO_MAP;
						state_q <= ST_EMIT;
					end else begin
						dx_q <= (KW+1)'($signed(sx_q)) - (KW+1)'($signed(rx_q));
						dy_q <= (KW+1)'($signed(sy_q)) - (KW+1)'($signed(ry_q));
						dz_q <= (KW+1)'($signed(sz_q)) - (KW+1)'($signed(rz_q));
						tpri_q <= rpri_q;
						state_q <= ST_SW_D1;
					end
				end
				ST_SW_D1: begin
					dx_q <= dx_q[KW] ? -dx_q : dx_q;
					dy_q <= dy_q[KW] ? -dy_q : dy_q;
					dz_q <= dz_q[KW] ? -dz_q : dz_q;
					acc_q <= '0;
					far_q <= 1'b0;
					tmatch_q <= 1'b0;
					state_q <= ST_SW_D2;
				end
				ST_SW_D2: begin
					acc_q <= sq;
					far_q <= (dx_q > (KW+1)'(merge_distance));
					state_q <= ST_SW_D3;
				end
				ST_SW_D3: begin
					if (!tmatch_q) begin
						acc_q <= acc_q + sq;
						far_q <= far_q || (dy_q > (KW+1)'(merge_distance));
						tmatch_q <= 1'b1;
					end else begin
						tmatch_q <= 1'b0;
						if (!far_q && dz_q <= (KW+1)'(merge_distance)
							&& acc_q + sq <= (2*KW+2)'(d2_q)) begin
							map_q <= (tpri_q != ssdpm_pkg::NO_MAP)
								? (follow_mode ? tpri_q : ssdpm_pkg::NO_MAP)
								: MW'(rid_q);
							state_q <= ST_EMIT;
						end else begin
							t_q <= t_q + 1'b1;
							state_q <= ST_SW_TGT;
						end
					end
				end
				ST_EMIT: begin
					if (!res_v_q || res_ready) begin
						res_v_q <= 1'b1;
						res_q <= '{id: sid_q, map: map_q, last: last_q};
						s_q <= s_q + 1'b1;
						state_q <= ST_SW_SRC;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// tmatch_q alternates the two squarer passes in ST_SW_D3; cleared on entry.

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= CW'(SET_DEPTH) && scnt_q <= CW'(SET_DEPTH))
		else $error("set count beyond depth");
	a_lb_order: assert property (@(posedge clk) disable iff (!arst_n)
		lb_q <= tcnt_q)
		else $error("lower bound past target count");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && !res_ready |=> res_v_q && $stable(res_q))
		else $error("result changed while stalled");

endmodule

@@ rtl/sorted_sweep_duplicate_point_map.sv @@
// Load: a point enters the queue, then is stored through the single-port store by
// an insertion sort that reads, compares and moves one entry at a time and then
// writes the point (the write follows the read directly when it ends at the bottom).
// Sweep after the final item: each source is read, then targets are skipped or
// distance-tested (one shared squarer, one axis per cycle).
// Reset is asynchronous, active low; it empties both sets and the queue.
module sorted_sweep_duplicate_point_map #(
	parameter int SET_DEPTH = ssdpm_pkg::SET_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [30:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// tdata: point_id[15:0], coord_x[47:16], coord_y[79:48], coord_z[111:80],
	// prior_map[128:112], zero fill to 136 bits.
	input logic [135:0] s_tdata,
	input logic s_tuser, // action
	input logic s_tlast, // final_item
	output logic m_tvalid,
	input logic m_tready,
	// tdata: source_id[15:0], map_value[32:16], zero fill to 40 bits.
	output logic [39:0] m_tdata,
	output logic m_tlast // last_result
);

	logic [ssdpm_pkg::DIST_W-1:0] dist_q;
	logic follow_q;
	ssdpm_pkg::point_t in_pt, q_pt;
	logic q_valid, q_ready;
	ssdpm_pkg::result_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= ssdpm_pkg::DIST_RESET;
			follow_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssdpm_pkg::REG_MERGE_DIST: dist_q <= cfg_data;
				ssdpm_pkg::REG_FOLLOW: follow_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front end: unpack the request into a point.
	assign in_pt = '{is_source: s_tuser, final_mark: s_tlast, id: s_tdata[15:0],
		x: s_tdata[47:16], y: s_tdata[79:48], z: s_tdata[111:80],
		prior: s_tdata[128:112]};

	ssdpm_fifo #(.DEPTH(4)) u_fifo (
		.clk, .arst_n,
		.wr_valid(s_tvalid), .wr_ready(s_tready), .wr_data(in_pt),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_pt)
	);

	ssdpm_sweep #(.SET_DEPTH(SET_DEPTH)) u_sweep (
		.clk, .arst_n,
		.merge_distance(dist_q), .follow_mode(follow_q),
		.pt_valid(q_valid), .pt_ready(q_ready), .pt_data(q_pt),
		.res_valid(m_tvalid), .res_ready(m_tready), .res_data(res)
	);

	assign m_tdata = {7'd0, res.map, res.id};
	assign m_tlast = res.last;

endmodule

@@ sim/tb_sorted_sweep_duplicate_point_map.sv @@
`timescale 1ns / 1ps

module tb_sorted_sweep_duplicate_point_map;

	localparam int DEPTH = ssdpm_pkg::SET_DEPTH_DEF;

	// One point request as the driver sends it.
	typedef struct {
		logic action;
		logic [ssdpm_pkg::ID_W-1:0] id;
		logic signed [ssdpm_pkg::CRD_W-1:0] x;
		logic signed [ssdpm_pkg::CRD_W-1:0] y;
		logic signed [ssdpm_pkg::CRD_W-1:0] z;
		logic signed [ssdpm_pkg::MAP_W-1:0] prior;
		logic final_mark;
	} point_req_t;

	// One mapping result, either expected or observed.
	typedef struct {
		logic [ssdpm_pkg::ID_W-1:0] id;
		logic [ssdpm_pkg::MAP_W-1:0] map;
		logic last;
	} map_res_t;

	// A stored point inside the predictor.
	typedef struct {
		longint x, y, z, sum;
		int id;
		int prior;
	} stored_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = ssdpm_pkg::REG_MERGE_DIST;
	logic [30:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [135:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic m_tlast;

	point_req_t pending_points[$];
	map_res_t expected_maps[$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	bit hold_request = 1'b0;

	// Predictor state and configuration.
	stored_pt_t tgt_set[$];
	stored_pt_t src_set[$];
	longint merge_radius = 655;
	bit follow_on = 1'b0;

	sorted_sweep_duplicate_point_map u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Insert keeping sum order, ties by ascending id, then load order.
	function automatic void insert_sorted(ref stored_pt_t set[$], input stored_pt_t p);
		int pos;
		if (set.size() >= DEPTH)
			return;
		pos = set.size();
		while (pos > 0 && (set[pos-1].sum > p.sum ||
				(set[pos-1].sum == p.sum && set[pos-1].id > p.id)))
			pos--;
		set.insert(pos, p);
	endfunction

	function automatic bit in_radius(stored_pt_t a, stored_pt_t b, longint d);
		longint df[3];
		longint unsigned acc;
		longint unsigned m;
		acc = 0;
		df[0] = a.x - b.x;
		df[1] = a.y - b.y;
		df[2] = a.z - b.z;
		for (int k = 0; k < 3; k++) begin
			m = (df[k] < 0) ? -df[k] : df[k];
			if (m > d)
				return 1'b0;
			acc += m * m;
		end
		return acc <= d * d;
	endfunction

	// Store one point; on the final mark run the sweep and queue the results.
	task automatic predict_mapping(point_req_t r);
		stored_pt_t p;
		longint w;
		int lo;
		bit exhausted;
		int m;
		map_res_t res;
		p.x = r.x;
		p.y = r.y;
		p.z = r.z;
		p.sum = p.x + p.y + p.z;
		p.id = r.id;
		p.prior = r.prior;
		if (r.action == ssdpm_pkg::ACT_SOURCE)
			insert_sorted(src_set, p);
		else
			insert_sorted(tgt_set, p);
		if (!r.final_mark)
			return;
		w = (merge_radius * 113515 + 65535) >>> 16;
		lo = 0;
		exhausted = 1'b0;
		for (int s = 0; s < src_set.size(); s++) begin
			if (src_set[s].prior != -1)
				m = src_set[s].prior;
			else if (exhausted)
				m = -1;
			else begin
				m = -1;
				while (lo < tgt_set.size() && tgt_set[lo].sum < src_set[s].sum - w)
					lo++;
				if (lo >= tgt_set.size())
					exhausted = 1'b1;
				else begin
					for (int t = lo; t < tgt_set.size() &&
							tgt_set[t].sum <= src_set[s].sum + w; t++) begin
						if (in_radius(src_set[s], tgt_set[t], merge_radius)) begin
							if (tgt_set[t].prior != -1)
								m = follow_on ? tgt_set[t].prior : -1;
							else
								m = tgt_set[t].id;
							break;
						end
					end
				end
			end
			res.id = src_set[s].id[ssdpm_pkg::ID_W-1:0];
			res.map = m[ssdpm_pkg::MAP_W-1:0];
			res.last = (s + 1 == src_set.size());
			expected_maps.push_back(res);
		end
		tgt_set.delete();
		src_set.delete();
	endtask

	// Driver: offers the next pending point, honoring the sender idle rate.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (pending_points.size() > 0 &&
						$urandom_range(99, 0) >= send_idle_pct) begin
					point_req_t r;
					r = pending_points.pop_front();
					predict_mapping(r);
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, r.prior, r.z, r.y, r.x, r.id};
					s_tuser <= r.action;
					s_tlast <= r.final_mark;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver ready, with random stalls and one long hold-off.
	always @(posedge clk) begin
		if (hold_request && hold_cycles == 0)
			hold_cycles <= 600;
		else if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
		m_tready <= arst_n && hold_cycles <= 1 && !(hold_request && hold_cycles == 0)
			&& $urandom_range(99, 0) >= recv_idle_pct;
	end

	// Monitor: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_maps.size() == 0) begin
				$error("unexpected result id=%0d", m_tdata[15:0]);
				fail_count++;
			end else begin
				map_res_t e;
				e = expected_maps.pop_front();
				if (m_tdata[15:0] !== e.id) begin
					$error("source_id expected %0d got %0d", e.id, m_tdata[15:0]);
					fail_count++;
				end
				if (m_tdata[32:16] !== e.map) begin
					$error("map_value expected %0h got %0h", e.map, m_tdata[32:16]);
					fail_count++;
				end
				if (m_tlast !== e.last) begin
					$error("last_result expected %0b got %0b", e.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	function automatic point_req_t make_point(logic act, int id, longint x, longint y,
			longint z, int prior, logic fin);
		point_req_t r;
		r.action = act;
		r.id = id[ssdpm_pkg::ID_W-1:0];
		r.x = x[ssdpm_pkg::CRD_W-1:0];
		r.y = y[ssdpm_pkg::CRD_W-1:0];
		r.z = z[ssdpm_pkg::CRD_W-1:0];
		r.prior = prior[ssdpm_pkg::MAP_W-1:0];
		r.final_mark = fin;
		return r;
	endfunction

	function automatic int rand_prior(int unmapped_pct);
		if ($urandom_range(99, 0) < unmapped_pct)
			return -1;
		return $urandom_range(65535, 0);
	endfunction

	// A job of clustered points, so that many sources land near targets.
	task automatic queue_random_job(int n_tgt, int n_src, int spread);
		longint cx, cy, cz;
		int base;
		int u;
		cx = $signed($urandom()) >>> 2;
		cy = $signed($urandom()) >>> 2;
		cz = $signed($urandom()) >>> 2;
		base = $urandom_range(65535, 0);
		for (int i = 0; i < n_tgt; i++)
			pending_points.push_back(make_point(ssdpm_pkg::ACT_TARGET, base + i,
				cx + $urandom_range(2*spread, 0) - spread,
				cy + $urandom_range(2*spread, 0) - spread,
				cz + $urandom_range(2*spread, 0) - spread,
				rand_prior(80), 1'b0));
		for (int i = 0; i < n_src; i++) begin
			u = $urandom_range(99, 0);
			pending_points.push_back(make_point(ssdpm_pkg::ACT_SOURCE, base + 100 + i,
				cx + $urandom_range(2*spread, 0) - spread,
				cy + $urandom_range(2*spread, 0) - spread,
				cz + $urandom_range(2*spread, 0) - spread,
				rand_prior(85), 1'b0));
			// Occasionally a full-range noise point or a late target.
			if (u < 5)
				pending_points.push_back(make_point(ssdpm_pkg::ACT_TARGET, $urandom(),
					$signed($urandom()), $signed($urandom()), $signed($urandom()),
					rand_prior(50), 1'b0));
		end
		pending_points[$].final_mark = 1'b1;
	endtask

	task automatic drain_and_settle();
		wait (pending_points.size() == 0);
		@(posedge clk);
		wait (expected_maps.size() == 0 && !s_tvalid);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ssdpm_pkg::REG_MERGE_DIST)
			merge_radius = val;
		else
			follow_on = val[0];
	endtask

	initial begin
		#200000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset settings, exact hit, mapped source, mapped target.
		pending_points.push_back(make_point(ssdpm_pkg::ACT_TARGET, 5, 0, 0, 0, -1, 1'b0));
		pending_points.push_back(make_point(ssdpm_pkg::ACT_TARGET, 6, 100, 0, 0, 77, 1'b0));
		pending_points.push_back(make_point(ssdpm_pkg::ACT_TARGET, 65535, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, -1, 1'b0));
		pending_points.push_back(make_point(ssdpm_pkg::ACT_SOURCE, 10, 655, 0, 0, -1, 1'b0));
		pending_points.push_back(make_point(ssdpm_pkg::ACT_SOURCE, 11, 100, 10, 0, -1, 1'b0));
		pending_points.push_back(make_point(ssdpm_pkg::ACT_SOURCE, 0, 5, 5, 5, 65535, 1'b0));
		pending_points.push_back(make_point(ssdpm_pkg::ACT_SOURCE, 12, -32'sh80000000,
			-32'sh80000000, -32'sh80000000, -1, 1'b0));
		pending_points.push_back(make_point(ssdpm_pkg::ACT_SOURCE, 13, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, -1, 1'b0));
		// A target after sources, tied sum with smaller id.
		pending_points.push_back(make_point(ssdpm_pkg::ACT_TARGET, 1, 0, 0, 0, -1, 1'b1));
		// No sources: no results at all.
		pending_points.push_back(make_point(ssdpm_pkg::ACT_TARGET, 2, 1, 2, 3, -1, 1'b1));
		drain_and_settle();

		write_reg(ssdpm_pkg::REG_FOLLOW, 31'd1);
		write_reg(ssdpm_pkg::REG_MERGE_DIST, 31'h7fffffff);
		pending_points.push_back(make_point(ssdpm_pkg::ACT_TARGET, 3, 0, 0, 0, 1234, 1'b0));
		pending_points.push_back(make_point(ssdpm_pkg::ACT_SOURCE, 4, 32'h7fffffff,
			-32'sh80000000, 0, -1, 1'b0));
		pending_points.push_back(make_point(ssdpm_pkg::ACT_SOURCE, 8, 0, 0,
			-32'sh80000000, -1, 1'b1));
		drain_and_settle();

		write_reg(ssdpm_pkg::REG_MERGE_DIST, 31'd0);
		// Overflow the source set: entries beyond the depth are dropped.
		pending_points.push_back(make_point(ssdpm_pkg::ACT_TARGET, 9, 7, 7, 7, -1, 1'b0));
		for (int i = 0; i < DEPTH + 3; i++)
			pending_points.push_back(make_point(ssdpm_pkg::ACT_SOURCE, 200 + i, 7, 7,
				i % 3, -1, i == DEPTH + 2));
		drain_and_settle();

		// Random phases over several settings, idle patterns and a long hold-off.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 84 : 0;
			recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 33 : 0;
			for (int j = 0; j < 3; j++) begin
				case (j)
					0: write_reg(ssdpm_pkg::REG_MERGE_DIST,
						31'($urandom_range(20000, 0)));
					1: write_reg(ssdpm_pkg::REG_MERGE_DIST,
						31'($urandom_range(200000, 1000)));
					default: write_reg(ssdpm_pkg::REG_MERGE_DIST, 31'h7fffffff);
				endcase
				write_reg(ssdpm_pkg::REG_FOLLOW, 31'($urandom_range(1, 0)));
				if (ph == 2 && j == 0)
					hold_request = 1'b1;
				for (int k = 0; k < 3; k++) begin
					int nt, ns;
					nt = $urandom_range(DEPTH / 2 - 2, 0);
					ns = $urandom_range(DEPTH / 2, 1);
					queue_random_job(nt, ns, (j == 0) ? 3000 : 200000);
				end
				drain_and_settle();
				hold_request = 1'b0;
			end
		end

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ssdpm_pkg.sv
rtl/ssdpm_fifo.sv
rtl/ssdpm_sweep.sv
rtl/sorted_sweep_duplicate_point_map.sv
sim/tb_sorted_sweep_duplicate_point_map.sv
